### hw/rtl/assert_macros.svh
// Assertion macros shared by the address unit RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

### hw/rtl/gmau_pkg.sv
// Types and codes shared by the ghosted mesh address unit.
`timescale 1ns / 1ps
`default_nettype none
package gmau_pkg;

	localparam int unsigned AXES      = 3;
	localparam int unsigned MAX_SIDE  = 64;
	localparam int unsigned MAX_GHOST = 8;

	localparam logic [2:0] ACT_STORAGE_INDEX   = 3'd0;
	localparam logic [2:0] ACT_INTERIOR_TO_STO = 3'd1;
	localparam logic [2:0] ACT_STORAGE_TO_INT  = 3'd2;
	localparam logic [2:0] ACT_FACE_INDEX      = 3'd3;
	localparam logic [2:0] ACT_INTERIOR_TEST   = 3'd4;

	localparam logic [2:0] ST_OK           = 3'd0;
	localparam logic [2:0] ST_OUT_OF_RANGE = 3'd1;
	localparam logic [2:0] ST_NOT_INTERIOR = 3'd2;
	localparam logic [2:0] ST_BAD_NORMAL   = 3'd3;
	localparam logic [2:0] ST_BAD_CONFIG   = 3'd4;

	localparam logic [1:0] CFG_DIMENSION_COUNT = 2'd0;
	localparam logic [1:0] CFG_CELLS_PER_SIDE  = 2'd1;
	localparam logic [1:0] CFG_GHOST_WIDTH     = 2'd2;

	localparam logic [1:0] NORMAL_INVALID = 2'd3;

	// Per-axis evaluation of one item's coordinate.
	typedef struct packed {
		logic [7:0] extent;
		logic       in_range;
		logic [6:0] conv;
		logic       interior;
	} axis_res_t;

endpackage
`default_nettype wire

### hw/rtl/ghosted_mesh_address_unit_core.sv
// Top level of the ghosted mesh address unit.
// Takes one item per cycle while in_stall is low and returns one result per item: the item
// is registered, the per-axis checks and the two axis products are registered next, and
// the final multiply-add for the linear index feeds the result register. A stalled result
// holds the whole pipeline, so in_stall follows out_stall while a result waits.
// Configuration writes are always ready and must only be made while the unit is idle.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module ghosted_mesh_address_unit_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [6:0]        cfg_data,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [2:0]        action,
	input  wire logic signed [7:0] coord_x,
	input  wire logic signed [7:0] coord_y,
	input  wire logic signed [7:0] coord_z,
	input  wire logic [1:0]        face_normal,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [18:0]            linear_index,
	output logic [6:0]             out_x,
	output logic [6:0]             out_y,
	output logic [6:0]             out_z,
	output logic                   is_interior,
	output logic [2:0]             status
);
	import gmau_pkg::*;

	logic [1:0] dimension_count_q;
	logic [6:0] cells_per_side_q;
	logic [3:0] ghost_width_q;

	logic       en;
	logic       valid_s1;
	logic [2:0] action_s1;
	logic [7:0] coord_s1 [AXES];
	logic [1:0] normal_s1;

	axis_res_t  ares [AXES];
	logic [AXES-1:0] in_range;
	logic [AXES-1:0] interior;
	logic       cfg_ok;
	logic       normal_bad;

	logic [2:0] status_n;
	logic [6:0] conv_n [AXES];
	logic       inside_n;
	logic       lin_en;
	logic [15:0] p_y;
	logic [15:0] p_xy;

	logic        valid_s2;
	logic [2:0]  status_s2;
	logic [6:0]  conv_s2 [AXES];
	logic        inside_s2;
	logic [7:0]  x_s2;
	logic [7:0]  z_s2;
	logic [15:0] p_y_s2;
	logic [15:0] p_xy_s2;
	logic [23:0] z_prod;
	logic [18:0] lin_n;

	logic        valid_s3;
	logic [18:0] lin_s3;
	logic [6:0]  conv_s3 [AXES];
	logic        inside_s3;
	logic [2:0]  status_s3;

	// Configuration registers.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dimension_count_q <= 2'd3;
			cells_per_side_q  <= 7'd8;
			ghost_width_q     <= 4'd2;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_DIMENSION_COUNT: dimension_count_q <= cfg_data[1:0];
				CFG_CELLS_PER_SIDE:  cells_per_side_q  <= cfg_data;
				CFG_GHOST_WIDTH:     ghost_width_q     <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// The pipeline moves as a whole whenever the result register can take a new result.
	assign en       = !valid_s3 || !out_stall;
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			action_s1   <= action;
			coord_s1[0] <= coord_x;
			coord_s1[1] <= coord_y;
			coord_s1[2] <= coord_z;
			normal_s1   <= face_normal;
		end
	end

	for (genvar a = 0; a < AXES; a++) begin : g_axis
		gmau_axis u_axis (
			.action    (action_s1),
			.coord     (coord_s1[a]),
			.active    (dimension_count_q > 2'(a)),
			.is_normal (normal_s1 == 2'(a)),
			.side      (cells_per_side_q),
			.ghost     (ghost_width_q),
			.res       (ares[a])
		);
		assign in_range[a] = ares[a].in_range;
		assign interior[a] = ares[a].interior;
	end

	assign cfg_ok = (dimension_count_q != 2'd0) && (32'(dimension_count_q) <= AXES) &&
	                (cells_per_side_q >= 7'd2) && (32'(cells_per_side_q) <= MAX_SIDE) &&
	                !cells_per_side_q[0] && (32'(ghost_width_q) <= MAX_GHOST);
	assign normal_bad = (normal_s1 == NORMAL_INVALID) || (normal_s1 >= dimension_count_q);

	always_comb begin
		status_n = ST_OK;
		inside_n = 1'b0;
		lin_en   = 1'b0;
		for (int a = 0; a < AXES; a++) begin
			conv_n[a] = 7'd0;
		end
		if (!cfg_ok) begin
			status_n = ST_BAD_CONFIG;
		end else begin
			unique case (action_s1)
				ACT_STORAGE_INDEX: begin
					if (!(&in_range)) status_n = ST_OUT_OF_RANGE;
					else lin_en = 1'b1;
				end
				ACT_INTERIOR_TO_STO: begin
					if (!(&in_range)) begin
						status_n = ST_OUT_OF_RANGE;
					end else begin
						for (int a = 0; a < AXES; a++) conv_n[a] = ares[a].conv;
					end
				end
				ACT_STORAGE_TO_INT: begin
					if (!(&interior)) begin
						status_n = ST_NOT_INTERIOR;
					end else begin
						for (int a = 0; a < AXES; a++) conv_n[a] = ares[a].conv;
						inside_n = 1'b1;
					end
				end
				ACT_FACE_INDEX: begin
					if (normal_bad) status_n = ST_BAD_NORMAL;
					else if (!(&in_range)) status_n = ST_OUT_OF_RANGE;
					else lin_en = 1'b1;
				end
				ACT_INTERIOR_TEST: begin
					inside_n = &interior;
				end
				default: begin
					status_n = ST_OUT_OF_RANGE;
				end
			endcase
		end
	end

	assign p_y  = coord_s1[1] * ares[0].extent;
	assign p_xy = ares[0].extent * ares[1].extent;

	// Zeroed terms make the linear index come out as zero where it does not apply.
	always_ff @(posedge clk) begin
		if (en) begin
			status_s2 <= status_n;
			inside_s2 <= inside_n;
			conv_s2   <= conv_n;
			x_s2      <= lin_en ? coord_s1[0] : 8'd0;
			z_s2      <= lin_en ? coord_s1[2] : 8'd0;
			p_y_s2    <= lin_en ? p_y : 16'd0;
			p_xy_s2   <= p_xy;
		end
	end

	assign z_prod = z_s2 * p_xy_s2;
	assign lin_n  = 19'(z_prod + {8'b0, p_y_s2} + {16'b0, x_s2});

	always_ff @(posedge clk) begin
		if (en) begin
			lin_s3    <= lin_n;
			conv_s3   <= conv_s2;
			inside_s3 <= inside_s2;
			status_s3 <= status_s2;
		end
	end

	assign out_valid    = valid_s3;
	assign linear_index = lin_s3;
	assign out_x        = conv_s3[0];
	assign out_y        = conv_s3[1];
	assign out_z        = conv_s3[2];
	assign is_interior  = inside_s3;
	assign status       = status_s3;

	`ASSERT_IMPLIES(a_err_zero, clk, arst_n, out_valid && (status != ST_OK), (linear_index == 19'd0) && (out_x == 7'd0) && (out_y == 7'd0) && (out_z == 7'd0) && !is_interior, "error result carries nonzero fields")
	`ASSERT_IMPLIES(a_inside_ok, clk, arst_n, out_valid && is_interior, status == ST_OK, "interior flag set on an error result")
	`ASSERT_IMPLIES(a_stall_cause, clk, arst_n, in_stall, out_valid && out_stall, "input stalled without a waiting result")
	`ASSERT_IMPLIES(a_flow, clk, arst_n, valid_s2 && !in_stall, ##1 out_valid, "item lost between stage two and the result register")

endmodule
`default_nettype wire

### hw/rtl/gmau_axis.sv
// Range, interior and conversion logic for one mesh axis.
`timescale 1ns / 1ps
`default_nettype none
module gmau_axis (
	input  wire logic [2:0]          action,
	input  wire logic [7:0]          coord,
	input  wire logic                active,
	input  wire logic                is_normal,
	input  wire logic [6:0]          side,
	input  wire logic [3:0]          ghost,
	output gmau_pkg::axis_res_t      res
);
	import gmau_pkg::*;

	logic [7:0] storage_ext;
	logic [7:0] interior_ext;
	logic [7:0] face_ext;
	logic [7:0] ext;
	logic [7:0] ghost_w;
	logic [7:0] ghost_end;
	logic [7:0] plus_g;
	logic [7:0] minus_g;
	logic       nonneg;
	logic [6:0] conv;

	assign nonneg       = !coord[7];
	assign ghost_w      = {4'b0, ghost};
	assign storage_ext  = active ? ({1'b0, side} + {3'b0, ghost, 1'b0}) : 8'd1;
	assign interior_ext = active ? {1'b0, side} : 8'd1;
	assign face_ext     = interior_ext + {7'b0, is_normal};
	assign ghost_end    = ghost_w + {1'b0, side};
	assign plus_g       = coord + ghost_w;
	assign minus_g      = coord - ghost_w;

	always_comb begin
		if (action == ACT_FACE_INDEX) begin
			ext = face_ext;
		end else if (action == ACT_INTERIOR_TO_STO) begin
			ext = interior_ext;
		end else begin
			ext = storage_ext;
		end
	end

	always_comb begin
		if (!active) begin
			conv = 7'd0;
		end else if (action == ACT_INTERIOR_TO_STO) begin
			conv = plus_g[6:0];
		end else begin
			conv = minus_g[6:0];
		end
	end

	assign res.extent   = ext;
	assign res.in_range = nonneg && (coord < ext);
	// An inactive axis only holds the single cell at zero.
	assign res.interior = active ? (nonneg && (coord >= ghost_w) && (coord < ghost_end))
	                             : (coord == 8'd0);
	assign res.conv     = conv;

endmodule
`default_nettype wire

### tb/sv/gmau_tb_pkg.sv
// Item types and the result scoreboard for the ghosted mesh address unit testbench.
`timescale 1ns / 1ps
package gmau_tb_pkg;
	import gmau_pkg::*;

	localparam int MAX_SIDE_CELLS  = 64;
	localparam int MAX_GHOST_CELLS = 8;
	localparam int ACTION_CODES    = 8;
	localparam int REPORT_LIMIT    = 10;

	typedef struct packed {
		logic [2:0] action;
		logic [7:0] coord_x;
		logic [7:0] coord_y;
		logic [7:0] coord_z;
		logic [1:0] face_normal;
	} mesh_request_t;

	typedef struct packed {
		logic [18:0] linear_index;
		logic [6:0]  out_x;
		logic [6:0]  out_y;
		logic [6:0]  out_z;
		logic        is_interior;
		logic [2:0]  status;
	} mesh_result_t;

	class mesh_address_scoreboard;
		int dims;
		int side;
		int ghost;
		mesh_result_t awaited_results [$];
		int mismatches;
		int strays;

		function new();
			// Register values after reset.
			dims = 3;
			side = 8;
			ghost = 2;
			mismatches = 0;
			strays = 0;
		endfunction

		function void write_register(logic [1:0] index, logic [6:0] data);
			case (index)
				CFG_DIMENSION_COUNT: dims = data[1:0];
				CFG_CELLS_PER_SIDE: side = data;
				CFG_GHOST_WIDTH: ghost = data[3:0];
				default: ;
			endcase
		endfunction

		function bit config_valid();
			return dims >= 1 && dims <= AXES && side >= 2 && side <= MAX_SIDE_CELLS &&
				(side & 1) == 0 && ghost <= MAX_GHOST_CELLS;
		endfunction

		function int interior_extent(int a);
			return (a < dims) ? side : 1;
		endfunction

		function int storage_extent(int a);
			return (a < dims) ? side + 2 * ghost : 1;
		endfunction

		function bit storage_is_interior(input int c [AXES]);
			for (int a = 0; a < AXES; a++) begin
				if (c[a] < 0 || c[a] >= storage_extent(a))
					return 1'b0;
				if (a < dims) begin
					if (c[a] < ghost || c[a] >= ghost + side)
						return 1'b0;
				end else if (c[a] != 0) begin
					return 1'b0;
				end
			end
			return 1'b1;
		endfunction

		function mesh_result_t predict_address(mesh_request_t rq);
			int c [AXES];
			int conv [AXES];
			int ext;
			int lin;
			int stride;
			int normal;
			bit bad;
			mesh_result_t r;
			r = '0;
			c[0] = $signed(rq.coord_x);
			c[1] = $signed(rq.coord_y);
			c[2] = $signed(rq.coord_z);
			conv = '{0, 0, 0};
			normal = rq.face_normal;
			lin = 0;
			stride = 1;
			bad = 1'b0;
			if (!config_valid()) begin
				r.status = ST_BAD_CONFIG;
			end else begin
				case (rq.action)
					ACT_STORAGE_INDEX: begin
						for (int a = 0; a < AXES && !bad; a++) begin
							ext = storage_extent(a);
							if (c[a] < 0 || c[a] >= ext) begin
								bad = 1'b1;
							end else begin
								lin += c[a] * stride;
								stride *= ext;
							end
						end
						if (bad) r.status = ST_OUT_OF_RANGE;
						else r.linear_index = 19'(lin);
					end
					ACT_INTERIOR_TO_STO: begin
						for (int a = 0; a < AXES && !bad; a++) begin
							if (c[a] < 0 || c[a] >= interior_extent(a)) bad = 1'b1;
							else conv[a] = (a < dims) ? c[a] + ghost : 0;
						end
						if (bad) begin
							r.status = ST_OUT_OF_RANGE;
						end else begin
							r.out_x = 7'(conv[0]);
							r.out_y = 7'(conv[1]);
							r.out_z = 7'(conv[2]);
						end
					end
					ACT_STORAGE_TO_INT: begin
						if (!storage_is_interior(c)) begin
							r.status = ST_NOT_INTERIOR;
						end else begin
							for (int a = 0; a < AXES; a++)
								conv[a] = (a < dims) ? c[a] - ghost : 0;
							r.out_x = 7'(conv[0]);
							r.out_y = 7'(conv[1]);
							r.out_z = 7'(conv[2]);
							r.is_interior = 1'b1;
						end
					end
					ACT_FACE_INDEX: begin
						if (normal == NORMAL_INVALID || normal >= dims) begin
							r.status = ST_BAD_NORMAL;
						end else begin
							// The face grid has one extra layer along the normal.
							for (int a = 0; a < AXES && !bad; a++) begin
								ext = interior_extent(a) + ((a == normal) ? 1 : 0);
								if (c[a] < 0 || c[a] >= ext) begin
									bad = 1'b1;
								end else begin
									lin += c[a] * stride;
									stride *= ext;
								end
							end
							if (bad) r.status = ST_OUT_OF_RANGE;
							else r.linear_index = 19'(lin);
						end
					end
					ACT_INTERIOR_TEST: r.is_interior = storage_is_interior(c);
					default: r.status = ST_OUT_OF_RANGE;
				endcase
			end
			return r;
		endfunction

		function void note_request(mesh_request_t rq);
			awaited_results.push_back(predict_address(rq));
		endfunction

		function void check_result(mesh_result_t got);
			mesh_result_t want;
			if (awaited_results.size() == 0) begin
				strays++;
				if (strays + mismatches <= REPORT_LIMIT)
					$display("unexpected result: idx=%0d x=%0d y=%0d z=%0d int=%0b st=%0d",
						got.linear_index, got.out_x, got.out_y, got.out_z,
						got.is_interior, got.status);
			end else begin
				want = awaited_results.pop_front();
				if (got.linear_index !== want.linear_index || got.out_x !== want.out_x ||
						got.out_y !== want.out_y || got.out_z !== want.out_z ||
						got.is_interior !== want.is_interior || got.status !== want.status) begin
					mismatches++;
					if (strays + mismatches <= REPORT_LIMIT)
						$display({"result mismatch: expected idx=%0d x=%0d y=%0d z=%0d ",
							"int=%0b st=%0d, got idx=%0d x=%0d y=%0d z=%0d int=%0b st=%0d"},
							want.linear_index, want.out_x, want.out_y, want.out_z,
							want.is_interior, want.status, got.linear_index, got.out_x,
							got.out_y, got.out_z, got.is_interior, got.status);
				end
			end
		endfunction

		function int pending_count();
			return awaited_results.size();
		endfunction

		function int failures();
			return mismatches + strays + awaited_results.size();
		endfunction
	endclass

endpackage

### tb/sv/tb_ghosted_mesh_address_unit_core.sv
// Self-checking testbench top for the ghosted mesh address unit core.
`timescale 1ns / 1ps
module tb_ghosted_mesh_address_unit_core;
	import gmau_pkg::*;
	import gmau_tb_pkg::*;

	localparam int CYCLE_LIMIT = 200000;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [1:0]        cfg_index = CFG_DIMENSION_COUNT;
	logic [6:0]        cfg_data = '0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [2:0]        action = ACT_STORAGE_INDEX;
	logic signed [7:0] coord_x = '0;
	logic signed [7:0] coord_y = '0;
	logic signed [7:0] coord_z = '0;
	logic [1:0]        face_normal = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [18:0]       linear_index;
	logic [6:0]        out_x;
	logic [6:0]        out_y;
	logic [6:0]        out_z;
	logic              is_interior;
	logic [2:0]        status;

	mesh_address_scoreboard sb;
	int send_gap_pct = 0;
	int recv_stall_pct = 0;
	int cycle_count = 0;

	ghosted_mesh_address_unit_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.coord_x(coord_x),
		.coord_y(coord_y),
		.coord_z(coord_z),
		.face_normal(face_normal),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.linear_index(linear_index),
		.out_x(out_x),
		.out_y(out_y),
		.out_z(out_z),
		.is_interior(is_interior),
		.status(status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	always @(posedge clk) out_stall <= ($urandom_range(0, 99) < recv_stall_pct);

	always @(posedge clk) begin
		mesh_request_t taken;
		mesh_result_t seen;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				taken.action = action;
				taken.coord_x = coord_x;
				taken.coord_y = coord_y;
				taken.coord_z = coord_z;
				taken.face_normal = face_normal;
				sb.note_request(taken);
			end
			if (out_valid && !out_stall) begin
				seen.linear_index = linear_index;
				seen.out_x = out_x;
				seen.out_y = out_y;
				seen.out_z = out_z;
				seen.is_interior = is_interior;
				seen.status = status;
				sb.check_result(seen);
			end
		end
	end

	function automatic mesh_request_t make_request(logic [2:0] act, int x, int y, int z,
			logic [1:0] normal);
		mesh_request_t rq;
		rq.action = act;
		rq.coord_x = 8'(x);
		rq.coord_y = 8'(y);
		rq.coord_z = 8'(z);
		rq.face_normal = normal;
		return rq;
	endfunction

	// Mostly coordinates inside the frame the action works in, the rest at and past the
	// edges or anywhere in the signed range.
	function automatic mesh_request_t random_request();
		mesh_request_t rq;
		int v [AXES];
		int ext;
		bit clean;
		if ($urandom_range(0, 99) < 4)
			rq.action = 3'($urandom_range(ACT_INTERIOR_TEST + 1, ACTION_CODES - 1));
		else
			rq.action = 3'($urandom_range(ACT_STORAGE_INDEX, ACT_INTERIOR_TEST));
		if (rq.action == ACT_FACE_INDEX && sb.dims >= 1 && $urandom_range(0, 99) < 85)
			rq.face_normal = 2'($urandom_range(0, sb.dims - 1));
		else
			rq.face_normal = 2'($urandom_range(0, NORMAL_INVALID));
		clean = ($urandom_range(0, 99) < 75);
		for (int a = 0; a < AXES; a++) begin
			case (rq.action)
				ACT_INTERIOR_TO_STO: ext = sb.interior_extent(a);
				ACT_FACE_INDEX:
					ext = sb.interior_extent(a) + ((a == rq.face_normal) ? 1 : 0);
				default: ext = sb.storage_extent(a);
			endcase
			if (ext < 1)
				ext = 1;
			if (clean) begin
				v[a] = $urandom_range(0, ext - 1);
			end else begin
				case ($urandom_range(0, 5))
					0: v[a] = -1;
					1: v[a] = ext;
					2: v[a] = 0;
					3: v[a] = ext - 1;
					default: v[a] = $urandom_range(0, 255);
				endcase
			end
		end
		rq.coord_x = 8'(v[0]);
		rq.coord_y = 8'(v[1]);
		rq.coord_z = 8'(v[2]);
		return rq;
	endfunction

	task automatic send_request(mesh_request_t rq);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= rq.action;
		coord_x <= rq.coord_x;
		coord_y <= rq.coord_y;
		coord_z <= rq.coord_z;
		face_normal <= rq.face_normal;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic wait_for_drain();
		in_valid <= 1'b0;
		// Waiting on the clock first lets the monitor note an item taken at the current edge.
		@(posedge clk);
		while (sb.pending_count() > 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_register(logic [1:0] index, logic [6:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.write_register(index, data);
	endtask

	task automatic run_phase(logic [6:0] dims_word, logic [6:0] side_word,
			logic [6:0] ghost_word, int count, int sender_pct, int receiver_pct);
		wait_for_drain();
		write_register(CFG_DIMENSION_COUNT, dims_word);
		write_register(CFG_CELLS_PER_SIDE, side_word);
		write_register(CFG_GHOST_WIDTH, ghost_word);
		cfg_valid <= 1'b0;
		send_gap_pct = sender_pct;
		recv_stall_pct = receiver_pct;
		for (int i = 0; i < count; i++) begin
			// Halfway through, the sender holds off until the pipeline has emptied.
			if (i == count / 2)
				wait_for_drain();
			send_request(random_request());
		end
	endtask

	initial begin
		sb = new();
		send_gap_pct = 12;
		recv_stall_pct = 53;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset configuration: three axes, eight interior cells, two ghost layers.
		send_request(make_request(ACT_STORAGE_INDEX, 0, 0, 0, 0));
		send_request(make_request(ACT_STORAGE_INDEX, 11, 11, 11, 1));
		send_request(make_request(ACT_STORAGE_INDEX, 12, 0, 0, 2));
		send_request(make_request(ACT_STORAGE_INDEX, 0, -1, 0, 0));
		send_request(make_request(ACT_STORAGE_INDEX, -128, 127, -128, NORMAL_INVALID));
		send_request(make_request(ACT_INTERIOR_TO_STO, 0, 0, 0, 0));
		send_request(make_request(ACT_INTERIOR_TO_STO, 7, 7, 7, 1));
		send_request(make_request(ACT_INTERIOR_TO_STO, 0, 0, 8, 2));
		send_request(make_request(ACT_INTERIOR_TO_STO, -1, 3, 3, 0));
		send_request(make_request(ACT_STORAGE_TO_INT, 2, 2, 2, 0));
		send_request(make_request(ACT_STORAGE_TO_INT, 9, 9, 9, 1));
		send_request(make_request(ACT_STORAGE_TO_INT, 1, 5, 5, 2));
		send_request(make_request(ACT_STORAGE_TO_INT, 5, 10, 5, 0));
		send_request(make_request(ACT_FACE_INDEX, 8, 7, 7, 0));
		send_request(make_request(ACT_FACE_INDEX, 7, 8, 7, 1));
		send_request(make_request(ACT_FACE_INDEX, 0, 0, 8, 2));
		send_request(make_request(ACT_FACE_INDEX, 3, 3, 3, NORMAL_INVALID));
		send_request(make_request(ACT_FACE_INDEX, 0, 9, 0, 1));
		send_request(make_request(ACT_FACE_INDEX, -1, 0, 0, 0));
		send_request(make_request(ACT_INTERIOR_TEST, 2, 2, 2, 0));
		send_request(make_request(ACT_INTERIOR_TEST, 0, 0, 0, 1));
		send_request(make_request(ACT_INTERIOR_TEST, 9, 9, 9, 2));
		for (int k = ACT_INTERIOR_TEST + 1; k < ACTION_CODES; k++)
			send_request(make_request(3'(k), 1, 1, 1, 0));

		run_phase(7'd1, 7'd2, 7'd0, 200, 12, 53);
		run_phase(7'd3, 7'd64, 7'd8, 200, 12, 53);
		run_phase(7'd0, 7'd8, 7'd2, 40, 12, 53);
		run_phase(7'd2, 7'd10, 7'd3, 200, 12, 53);
		run_phase(7'd3, 7'd7, 7'd2, 40, 53, 12);
		// Only the low two bits of the axis count are kept, so this is two axes.
		run_phase(7'd6, 7'd64, 7'd0, 200, 53, 12);
		run_phase(7'd3, 7'd66, 7'd1, 40, 53, 12);
		run_phase(7'd2, 7'd32, 7'd9, 40, 53, 12);
		run_phase(7'd3, 7'd2, 7'd8, 200, 53, 12);
		run_phase(7'd1, 7'd0, 7'd4, 40, 0, 0);
		run_phase(7'd1, 7'd64, 7'd8, 200, 0, 0);
		run_phase(7'd3, 7'd16, 7'd15, 40, 0, 0);
		run_phase(7'd2, 7'd4, 7'd1, 200, 0, 0);

		wait_for_drain();
		repeat (10) @(posedge clk);
		if (sb.failures() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
